// ===== rtl/mh2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared constants and types for the streaming 32-bit MurmurHash2 block.
// ----------------------------------------------------------------------------
package mh2_pkg;

    localparam logic [31:0] MH_M       = 32'h5bd1_e995;
    localparam int unsigned MH_R       = 24;
    localparam int unsigned MH_FIN_A   = 13;
    localparam int unsigned MH_FIN_B   = 15;
    localparam logic [31:0] SEED_RESET = 32'hdead_beef;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [2:0] NB_FULL = 3'd4;

    typedef enum logic [2:0] {
        K_NOP,
        K_START,
        K_WORD,
        K_TAIL,
        K_FINAL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] opnd;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/mh2_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_if
// Valid/ready channels: input items, hash results, seed writes.
// ----------------------------------------------------------------------------
interface mh2_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic [31:0] length;

    modport source (output valid, op, data_word, valid_bytes, length, input ready);
    modport sink   (input valid, op, data_word, valid_bytes, length, output ready);
endinterface

interface mh2_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash;

    modport source (output valid, hash, input ready);
    modport sink   (input valid, hash, output ready);
endinterface

interface mh2_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mh2_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_front
// Accepts items, classifies them and runs the two-multiply word mix ahead.
// ----------------------------------------------------------------------------
module mh2_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mh2_cfg_if.sink          i_cfg,
    mh2_in_if.sink           i_in,
    output logic             o_cmd_valid,
    output mh2_pkg::t_cmd    o_cmd,
    input  wire              i_cmd_ready
);

    logic [31:0]   r_seed;
    logic          r_s1_valid, r_s2_valid;
    mh2_pkg::t_cmd r_s1, r_s2;
    mh2_pkg::t_cmd n_s1, n_s2;
    logic          advance;
    logic          in_xfer;
    logic [31:0]   tail_mask;
    logic [31:0]   k_mix;

    assign advance    = !r_s2_valid || i_cmd_ready;
    assign i_in.ready = advance;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        case (i_in.valid_bytes)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            default: tail_mask = 32'h00ff_ffff;
        endcase
    end

    always_comb begin
        n_s1.kind = mh2_pkg::K_NOP;
        n_s1.opnd = i_in.data_word;
        case (i_in.op)
            mh2_pkg::OP_START: begin
                n_s1.kind = mh2_pkg::K_START;
                n_s1.opnd = r_seed ^ i_in.length;
            end
            mh2_pkg::OP_DATA: begin
                if (i_in.valid_bytes == mh2_pkg::NB_FULL) begin
                    n_s1.kind = mh2_pkg::K_WORD;
                    n_s1.opnd = i_in.data_word * mh2_pkg::MH_M;
                end else if (i_in.valid_bytes != 3'd0 && i_in.valid_bytes < mh2_pkg::NB_FULL) begin
                    n_s1.kind = mh2_pkg::K_TAIL;
                    n_s1.opnd = i_in.data_word & tail_mask;
                end
            end
            mh2_pkg::OP_FINISH: begin
                n_s1.kind = mh2_pkg::K_FINAL;
            end
            default: begin
                n_s1.kind = mh2_pkg::K_NOP;
            end
        endcase
    end

    assign k_mix = r_s1.opnd ^ (r_s1.opnd >> mh2_pkg::MH_R);

    always_comb begin
        n_s2 = r_s1;
        if (r_s1.kind == mh2_pkg::K_WORD) begin
            n_s2.opnd = k_mix * mh2_pkg::MH_M;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= mh2_pkg::SEED_RESET;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_seed <= i_cfg.data;
            end
            if (advance) begin
                r_s2_valid <= r_s1_valid;
                r_s1_valid <= in_xfer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2 <= n_s2;
            if (in_xfer) begin
                r_s1 <= n_s1;
            end
        end
    end

    assign o_cmd_valid = r_s2_valid;
    assign o_cmd       = r_s2;

endmodule
`default_nettype wire

// ===== rtl/mh2_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_fifo
// Small command queue between the front and back sections.
// ----------------------------------------------------------------------------
module mh2_fifo #(
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push_valid,
    input  mh2_pkg::t_cmd    i_push,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output mh2_pkg::t_cmd    o_pop,
    input  wire              i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mh2_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mh2_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_back
// Hash state update: one multiply by m per command, result register.
// ----------------------------------------------------------------------------
module mh2_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cmd_valid,
    input  mh2_pkg::t_cmd    i_cmd,
    output logic             o_cmd_ready,
    mh2_out_if.source        o_out
);

    logic [31:0] r_hash;
    logic        r_out_valid;
    logic [31:0] n_hash;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic        take;

    assign o_cmd_ready = !r_out_valid || o_out.ready;
    assign take        = i_cmd_valid && o_cmd_ready;

    always_comb begin
        case (i_cmd.kind)
            mh2_pkg::K_TAIL:  mul_a = r_hash ^ i_cmd.opnd;
            mh2_pkg::K_FINAL: mul_a = r_hash ^ (r_hash >> mh2_pkg::MH_FIN_A);
            default:          mul_a = r_hash;
        endcase
    end

    assign prod = mul_a * mh2_pkg::MH_M;

    always_comb begin
        case (i_cmd.kind)
            mh2_pkg::K_START: n_hash = i_cmd.opnd;
            mh2_pkg::K_WORD:  n_hash = prod ^ i_cmd.opnd;
            mh2_pkg::K_TAIL:  n_hash = prod;
            mh2_pkg::K_FINAL: n_hash = prod ^ (prod >> mh2_pkg::MH_FIN_B);
            default:          n_hash = r_hash;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_hash      <= n_hash;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.hash  = r_hash;

endmodule
`default_nettype wire

// ===== rtl/murmur2_hash32_stream_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur2_hash32_stream_top
// Streaming 32-bit MurmurHash2 over little-endian words, one result per item.
//
//   channel  dir  payload                                 transfer
//   i_cfg    in   data (seed)                             valid & ready
//   i_in     in   op, data_word, valid_bytes, length      valid & ready
//   o_out    out  hash                                    valid & ready
//
// Sustained rate is one item per cycle while the output is not stalled; the back
// loop holds one 32x32 multiply by m between hash register reads.
// From input transfer to result valid, an item passes the first word-mix stage,
// the second stage, the command queue and the hash register, in that order.
// Synchronous active-low reset; the seed resets to 0xdeadbeef, hash to 0.
// A stalled output holds the back section; the queue absorbs the front.
// ----------------------------------------------------------------------------
module murmur2_hash32_stream_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mh2_cfg_if.sink    i_cfg,
    mh2_in_if.sink     i_in,
    mh2_out_if.source  o_out
);

    logic          f_valid, f_ready;
    mh2_pkg::t_cmd f_cmd;
    logic          q_valid, q_ready;
    mh2_pkg::t_cmd q_cmd;

    mh2_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_in        (i_in),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (f_ready)
    );

    mh2_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push       (f_cmd),
        .o_push_ready (f_ready),
        .o_pop_valid  (q_valid),
        .o_pop        (q_cmd),
        .i_pop_ready  (q_ready)
    );

    mh2_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ===== rtl/mh2_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mh2_checker
// Port-level checks on the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module mh2_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire [31:0] i_out_hash,
    input  wire        i_cfg_ready
);

    logic [7:0] r_pend;
    logic       in_xfer, out_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_pend <= r_pend + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_hash)))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (r_pend != 8'd0))
        else $error("result without a pending item");

    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_cfg_ready)
        else $error("seed write port not ready");

endmodule

bind murmur2_hash32_stream_top mh2_checker u_mh2_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hash  (o_out.hash),
    .i_cfg_ready (i_cfg.ready)
);
`default_nettype wire

// ===== sim/tb_murmur2_hash32_stream_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur2_hash32_stream_top
// Self-checking bench for the streaming MurmurHash2 block. Directed corner
// items come first, then random messages (start, words, tail, finish) with
// noise items mixed in. The seed is rewritten between phases. Each input
// transfer is run through a bit-accurate hash predictor, and every output
// transfer is compared in order. Random back-pressure and sender gaps are
// applied, plus one long output hold that fills the block.
// ----------------------------------------------------------------------------
module tb_murmur2_hash32_stream_top;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         LONG_HOLD   = 100;
    localparam int         SETTLE      = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic [31:0] length;
    } t_hash_item;

    class hash_scoreboard;
        logic [31:0] seed;
        logic [31:0] running_hash;
        logic [31:0] expected_hashes[$];
        int          errors;

        function new();
            seed         = mh2_pkg::SEED_RESET;
            running_hash = 32'h0;
            errors       = 0;
        endfunction

        function void note_item(t_hash_item it);
            logic [31:0] h;
            logic [31:0] k;
            h = running_hash;
            case (it.op)
                mh2_pkg::OP_START: begin
                    h = seed ^ it.length;
                end
                mh2_pkg::OP_DATA: begin
                    if (it.valid_bytes == mh2_pkg::NB_FULL) begin
                        k = it.data_word * mh2_pkg::MH_M;
                        k = k ^ (k >> mh2_pkg::MH_R);
                        k = k * mh2_pkg::MH_M;
                        h = (h * mh2_pkg::MH_M) ^ k;
                    end else if (it.valid_bytes >= 3'd1 && it.valid_bytes <= 3'd3) begin
                        h = h ^ (it.data_word & ((32'd1 << (32'd8 * it.valid_bytes)) - 32'd1));
                        h = h * mh2_pkg::MH_M;
                    end
                end
                mh2_pkg::OP_FINISH: begin
                    h = h ^ (h >> mh2_pkg::MH_FIN_A);
                    h = h * mh2_pkg::MH_M;
                    h = h ^ (h >> mh2_pkg::MH_FIN_B);
                end
                default: ;
            endcase
            running_hash = h;
            expected_hashes.push_back(h);
        endfunction

        function void check_hash(logic [31:0] got);
            logic [31:0] exp_hash;
            if (expected_hashes.size() == 0) begin
                $error("hash: unexpected result, expected none, actual %08h", got);
                errors++;
            end else begin
                exp_hash = expected_hashes.pop_front();
                if (got !== exp_hash) begin
                    $error("hash mismatch: expected %08h actual %08h", exp_hash, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mh2_cfg_if cfg_if ();
    mh2_in_if  in_if ();
    mh2_out_if out_if ();

    murmur2_hash32_stream_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    hash_scoreboard sb = new();

    int items_sent = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    bit quiet      = 1'b0;
    bit hold_long  = 1'b0;
    int idle_cycles = 0;

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // transfer monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.seed = cfg_if.data;
            if (in_if.valid && in_if.ready)
                sb.note_item('{in_if.op, in_if.data_word, in_if.valid_bytes, in_if.length});
            if (out_if.valid && out_if.ready)
                sb.check_hash(out_if.hash);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result receiver back-pressure
    initial begin : rx_ready
        int n;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_long) begin
                hold_long = 1'b0;
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end else if (!quiet && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                n = $urandom_range(16, 1);
                out_if.ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] w,
                             input logic [2:0] nb, input logic [31:0] len);
        if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.data_word   <= w;
        in_if.valid_bytes <= nb;
        in_if.length      <= len;
        do @(posedge clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(2'($urandom()), $urandom(), 3'($urandom()), $urandom());
    endtask

    task automatic send_message();
        int unsigned len;
        int unsigned words;
        if ($urandom_range(9) == 0)
            len = $urandom();
        else
            len = $urandom_range(40);
        send_item(mh2_pkg::OP_START, $urandom(), 3'($urandom()), len);
        words = len / 4;
        if (words > 12)
            words = $urandom_range(12);
        repeat (words) send_item(mh2_pkg::OP_DATA, $urandom(), mh2_pkg::NB_FULL, $urandom());
        if (len % 4 != 0)
            send_item(mh2_pkg::OP_DATA, $urandom(), 3'(len % 4), $urandom());
        send_item(mh2_pkg::OP_FINISH, $urandom(), 3'($urandom()), $urandom());
    endtask

    task automatic send_traffic(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 15)
                send_noise();
            else
                send_message();
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.expected_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int gap_tbl[6]   = '{0, 20, 50, 10, 30, 5};
        int stall_tbl[6] = '{0, 20, 10, 50, 30, 5};
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.op          = mh2_pkg::OP_START;
        in_if.data_word   = 32'h0;
        in_if.valid_bytes = 3'd0;
        in_if.length      = 32'h0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = 32'h0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // corner items on the reset seed
        gap_pct   = 20;
        stall_pct = 20;
        send_item(mh2_pkg::OP_DATA,   32'h0000_0000, mh2_pkg::NB_FULL, 32'h0);
        send_item(mh2_pkg::OP_START,  32'hffff_ffff, 3'd7,             32'h0);
        send_item(mh2_pkg::OP_DATA,   32'hffff_ffff, mh2_pkg::NB_FULL, 32'hffff_ffff);
        send_item(mh2_pkg::OP_DATA,   32'h8000_0001, mh2_pkg::NB_FULL, 32'h0);
        send_item(mh2_pkg::OP_DATA,   32'hffff_ffff, 3'd1,             32'hffff_ffff);
        send_item(mh2_pkg::OP_DATA,   32'hffff_ffff, 3'd2,             32'h0);
        send_item(mh2_pkg::OP_DATA,   32'ha5a5_a5a5, 3'd3,             32'h0);
        send_item(mh2_pkg::OP_DATA,   32'hffff_ffff, 3'd0,             32'hffff_ffff);
        send_item(mh2_pkg::OP_DATA,   32'hffff_ffff, 3'd5,             32'h0);
        send_item(mh2_pkg::OP_DATA,   32'h1234_5678, 3'd6,             32'h0);
        send_item(mh2_pkg::OP_DATA,   32'hffff_ffff, 3'd7,             32'h0);
        send_item(OP_UNUSED,          32'hffff_ffff, mh2_pkg::NB_FULL, 32'hffff_ffff);
        send_item(mh2_pkg::OP_FINISH, 32'hffff_ffff, mh2_pkg::NB_FULL, 32'hffff_ffff);
        send_item(mh2_pkg::OP_FINISH, 32'h0,         3'd0,             32'h0);
        send_item(mh2_pkg::OP_START,  32'h0,         3'd0,             32'hffff_ffff);
        drain();

        write_seed(32'h0000_0000);
        send_item(mh2_pkg::OP_START,  32'hffff_ffff, mh2_pkg::NB_FULL, 32'h0);
        send_item(mh2_pkg::OP_FINISH, 32'h0,         3'd0,             32'h0);
        send_item(mh2_pkg::OP_DATA,   32'h0000_00ff, 3'd1,             32'h0);
        drain();

        write_seed(32'hffff_ffff);
        send_item(mh2_pkg::OP_START,  32'h0,         3'd0,             32'hffff_ffff);
        send_item(mh2_pkg::OP_START,  32'h0,         3'd0,             32'h0);
        send_item(mh2_pkg::OP_DATA,   32'hffff_ffff, mh2_pkg::NB_FULL, 32'h0);
        send_item(mh2_pkg::OP_FINISH, 32'h0,         3'd0,             32'h0);
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            write_seed($urandom());
            gap_pct   = gap_tbl[seg];
            stall_pct = stall_tbl[seg];
            if (seg == 2) begin
                // long output hold while items keep coming
                gap_pct   = 0;
                hold_long = 1'b1;
                send_traffic(40);
                gap_pct   = gap_tbl[seg];
            end
            send_traffic(260);
            drain();
        end

        write_seed(mh2_pkg::SEED_RESET);
        quiet = 1'b1;
        send_traffic(220);
        drain();

        if (sb.errors == 0 && sb.expected_hashes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
